>>> sv/sli_pkg.sv
// shared constants, codes and types of the sorted list block
package sli_pkg;

    localparam int CAPACITY = 16;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int VAL_W    = 32;
    localparam int COUNT_W  = 5;

    localparam logic MODE_INSERT = 1'b0;
    localparam logic MODE_DELETE = 1'b1;

    localparam logic [1:0] STATUS_OK        = 2'd0;
    localparam logic [1:0] STATUS_FULL      = 2'd1;
    localparam logic [1:0] STATUS_NOT_FOUND = 2'd2;
    localparam logic [1:0] STATUS_EMPTY     = 2'd3;

    typedef struct packed {
        logic load;
        logic exec;
    } sli_cmd_t;

    typedef struct packed {
        logic [1:0]         status;
        logic [COUNT_W-1:0] count;
        logic [VAL_W-1:0]   smallest;
        logic               smallest_valid;
    } sli_result_t;

endpackage

>>> sv/sli_ifs.sv
// request and response channel interfaces
interface sli_req_if
    import sli_pkg::*;
();
    logic               valid;
    logic               ready;
    logic               mode;
    logic [VAL_W-1:0]   value;

    modport source (output valid, output mode, output value, input ready);
    modport sink   (input valid, input mode, input value, output ready);
    modport mon    (input valid, input mode, input value, input ready);
endinterface

interface sli_rsp_if
    import sli_pkg::*;
();
    logic               valid;
    logic               ready;
    logic [1:0]         status;
    logic [COUNT_W-1:0] count;
    logic [VAL_W-1:0]   smallest;
    logic               smallest_valid;

    modport source (output valid, output status, output count, output smallest,
                    output smallest_valid, input ready);
    modport sink   (input valid, input status, input count, input smallest,
                    input smallest_valid, output ready);
    modport mon    (input valid, input status, input count, input smallest,
                    input smallest_valid, input ready);
endinterface

>>> sv/sorted_list_insert_delete.sv
// Sorted list of up to CAPACITY (16) signed 32-bit values kept in ascending order.
// Each request either inserts a value in order (mode 0) or deletes the first
// equal copy (mode 1) and yields one response with status, count and the
// smallest stored value. Every value sits in a cell of its own that compares
// against the operand and shifts to or from its neighbor, so the work for one
// item does not grow with how full the list is: first the request is registered,
// then the parallel compare and shift runs, which also loads the response register.
// A request is taken when the block is idle; a waiting response only holds
// the block while the next item wants to write its result.
module sorted_list_insert_delete
    import sli_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    sli_req_if.sink   req,
    sli_rsp_if.source rsp
);

    sli_cmd_t    cmd;
    sli_result_t result;

    sli_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req.ready),
        .rsp_valid (rsp.valid),
        .rsp_ready (rsp.ready),
        .cmd       (cmd)
    );

    sli_datapath u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .in_mode  (req.mode),
        .in_value (req.value),
        .result   (result)
    );

    assign rsp.status         = result.status;
    assign rsp.count          = result.count;
    assign rsp.smallest       = result.smallest;
    assign rsp.smallest_valid = result.smallest_valid;

endmodule

>>> sv/sli_ctrl.sv
// controller: sequences load, execute and the response transfer
module sli_ctrl
    import sli_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     req_valid,
    output logic     req_ready,
    output logic     rsp_valid,
    input  logic     rsp_ready,
    output sli_cmd_t cmd
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_EXEC = 1'b1;

    logic state_reg;
    logic state_next;
    logic rsp_valid_reg;
    logic rsp_valid_next;
    logic slot_free;

    assign req_ready = (state_reg == ST_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign slot_free = !rsp_valid_reg || rsp_ready;

    always_comb
    begin
        state_next     = state_reg;
        rsp_valid_next = rsp_valid_reg && !rsp_ready;
        cmd.load       = 1'b0;
        cmd.exec       = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                // result register must be free before the list is updated
                if (slot_free)
                begin
                    cmd.exec       = 1'b1;
                    rsp_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

endmodule

>>> sv/sli_datapath.sv
// datapath: row of value cells with local compare and shift, count and result
module sli_datapath
    import sli_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  sli_cmd_t         cmd,
    input  logic             in_mode,
    input  logic [VAL_W-1:0] in_value,
    output sli_result_t      result
);

    logic                 op_mode_reg;
    logic [VAL_W-1:0]     op_value_reg;
    logic [VAL_W-1:0]     val_reg  [CAPACITY];
    logic [VAL_W-1:0]     ins_val  [CAPACITY];
    logic [VAL_W-1:0]     del_val  [CAPACITY];
    logic [CAPACITY-1:0]  occupied;
    logic [CAPACITY-1:0]  below;
    logic [CAPACITY-1:0]  hit;
    logic [CNT_W-1:0]     count_reg;
    logic [CNT_W-1:0]     count_next;
    logic                 full;
    logic                 empty;
    logic                 found;
    logic                 ins_ok;
    logic                 del_ok;
    logic [1:0]           status_next;
    logic [VAL_W-1:0]     head_next;
    logic [31:0]          count_ext;
    sli_result_t          result_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_mode_reg  <= in_mode;
            op_value_reg <= in_value;
        end
    end

    genvar i;
    generate
        for (i = 0; i < CAPACITY; i++)
        begin : g_cell
            assign occupied[i] = (count_reg > CNT_W'(i));
            assign below[i]    = occupied[i] &&
                                 ($signed(val_reg[i]) < $signed(op_value_reg));
            assign hit[i]      = occupied[i] && (val_reg[i] == op_value_reg);

            // insert: keep smaller entries, new value at the boundary, shift the rest up
            if (i == 0)
            begin : g_first
                assign ins_val[i] = below[i] ? val_reg[i] : op_value_reg;
            end
            else
            begin : g_rest
                assign ins_val[i] = below[i]     ? val_reg[i] :
                                    below[i - 1] ? op_value_reg : val_reg[i - 1];
            end

            // delete: the first equal entry sits at the boundary, shift the rest down
            if (i == CAPACITY - 1)
            begin : g_last
                assign del_val[i] = val_reg[i];
            end
            else
            begin : g_inner
                assign del_val[i] = below[i] ? val_reg[i] : val_reg[i + 1];
            end

            always_ff @(posedge clk)
            begin
                if (ins_ok)
                begin
                    val_reg[i] <= ins_val[i];
                end
                else if (del_ok)
                begin
                    val_reg[i] <= del_val[i];
                end
            end
        end
    endgenerate

    assign full   = (count_reg == CNT_W'(CAPACITY));
    assign empty  = (count_reg == '0);
    assign found  = |hit;
    assign ins_ok = cmd.exec && (op_mode_reg == MODE_INSERT) && !full;
    assign del_ok = cmd.exec && (op_mode_reg == MODE_DELETE) && !empty && found;

    always_comb
    begin
        count_next = count_reg;
        if (ins_ok)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (del_ok)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_comb
    begin
        if (op_mode_reg == MODE_INSERT)
        begin
            status_next = full ? STATUS_FULL : STATUS_OK;
        end
        else if (empty)
        begin
            status_next = STATUS_EMPTY;
        end
        else
        begin
            status_next = found ? STATUS_OK : STATUS_NOT_FOUND;
        end
    end

    always_comb
    begin
        head_next = val_reg[0];
        if (ins_ok)
        begin
            head_next = ins_val[0];
        end
        else if (del_ok)
        begin
            head_next = del_val[0];
        end
    end

    assign count_ext = 32'(count_next);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.exec)
        begin
            result_reg.status         <= status_next;
            result_reg.count          <= count_ext[COUNT_W-1:0];
            result_reg.smallest       <= (count_next != '0) ? head_next : '0;
            result_reg.smallest_valid <= (count_next != '0);
        end
    end

    assign result = result_reg;

endmodule

>>> sv/sli_checker.sv
// port-level checks of the sorted list block and their bind
module sli_checker
    import sli_pkg::*;
(
    input logic               clk,
    input logic               rst_n,
    input logic               rsp_valid,
    input logic               rsp_ready,
    input logic [1:0]         rsp_status,
    input logic [COUNT_W-1:0] rsp_count,
    input logic [VAL_W-1:0]   rsp_smallest,
    input logic               rsp_smallest_valid
);

    // a response held back keeps its status and count
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=>
            rsp_valid && $stable(rsp_count) && $stable(rsp_status))
        else $error("response changed while stalled");

    a_valid_flag: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (rsp_smallest_valid == (rsp_count != '0)))
        else $error("smallest_valid disagrees with count");

    a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_smallest_valid |-> (rsp_smallest == '0))
        else $error("smallest not zero on empty list");

    a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp_status == STATUS_FULL) |-> (rsp_count == COUNT_W'(CAPACITY)))
        else $error("full status with list not full");

    a_empty_count: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp_status == STATUS_EMPTY) |-> (rsp_count == '0))
        else $error("empty status with entries held");

endmodule

bind sorted_list_insert_delete sli_checker u_sli_checker (
    .clk                (clk),
    .rst_n              (rst_n),
    .rsp_valid          (rsp.valid),
    .rsp_ready          (rsp.ready),
    .rsp_status         (rsp.status),
    .rsp_count          (rsp.count),
    .rsp_smallest       (rsp.smallest),
    .rsp_smallest_valid (rsp.smallest_valid)
);

>>> sim/sorted_list_insert_delete_test.sv
// self-checking testbench for the sorted list insert and delete block
module sorted_list_insert_delete_test
    import sli_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_ITEMS = 750;
    localparam int QUIET_LIMIT  = 5000;
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = 20;
    localparam int MAX_REPORTS  = 10;

    localparam logic TYPED     = 1'b1;
    localparam logic PREDICTED = 1'b0;
    localparam sli_result_t NO_WANT = '0;

    typedef struct packed {
        logic             mode;
        logic [VAL_W-1:0] value;
        logic             typed;
        sli_result_t      want;
    } stim_row_t;

    typedef struct packed {
        logic        typed;
        sli_result_t want;
    } row_note_t;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    sli_req_if req_ch();
    sli_rsp_if rsp_ch();

    sorted_list_insert_delete dut
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    int          sorted_vals[$];
    sli_result_t pending_results[$];
    row_note_t   row_notes[$];

    int mismatch_count  = 0;
    int quiet_cycles    = 0;
    int send_idle_pct   = 29;
    int recv_idle_pct   = 65;
    int hold_requests   = 0;
    int holds_done      = 0;
    int inserts_sent    = 0;
    int deletes_sent    = 0;
    int results_checked = 0;
    int peak_fill       = 0;
    int status_seen[4]  = '{0, 0, 0, 0};
    bit filling         = 1'b1;

    // directed rows: empty list, extremes, duplicates, filling to capacity, full, deletes
    stim_row_t directed_rows[24] = '{
        '{MODE_DELETE, 32'h0000_0000, TYPED, '{STATUS_EMPTY, 5'd0, 32'h0000_0000, 1'b0}},
        '{MODE_INSERT, 32'h7fff_ffff, TYPED, '{STATUS_OK, 5'd1, 32'h7fff_ffff, 1'b1}},
        '{MODE_INSERT, 32'h8000_0000, TYPED, '{STATUS_OK, 5'd2, 32'h8000_0000, 1'b1}},
        '{MODE_DELETE, 32'h0000_0000, TYPED, '{STATUS_NOT_FOUND, 5'd2, 32'h8000_0000, 1'b1}},
        '{MODE_INSERT, 32'h0000_0000, PREDICTED, NO_WANT},
        '{MODE_INSERT, 32'h0000_0000, PREDICTED, NO_WANT},
        '{MODE_INSERT, 32'hffff_ffff, PREDICTED, NO_WANT},
        '{MODE_INSERT, 32'h0000_0001, PREDICTED, NO_WANT},
        '{MODE_INSERT, 32'h7fff_ffff, PREDICTED, NO_WANT},
        '{MODE_INSERT, 32'h8000_0000, PREDICTED, NO_WANT},
        '{MODE_INSERT, 32'h5555_5555, PREDICTED, NO_WANT},
        '{MODE_INSERT, 32'haaaa_aaaa, PREDICTED, NO_WANT},
        '{MODE_INSERT, 32'h0001_0000, PREDICTED, NO_WANT},
        '{MODE_INSERT, 32'hfffe_0000, PREDICTED, NO_WANT},
        '{MODE_INSERT, 32'h0000_0007, PREDICTED, NO_WANT},
        '{MODE_INSERT, 32'hffff_fff9, PREDICTED, NO_WANT},
        '{MODE_INSERT, 32'h0000_0003, PREDICTED, NO_WANT},
        '{MODE_INSERT, 32'h0000_0003, PREDICTED, NO_WANT},
        '{MODE_INSERT, 32'h0000_002a, TYPED, '{STATUS_FULL, 5'd16, 32'h8000_0000, 1'b1}},
        '{MODE_DELETE, 32'h0000_0000, PREDICTED, NO_WANT},
        '{MODE_DELETE, 32'h8000_0000, PREDICTED, NO_WANT},
        '{MODE_DELETE, 32'h8000_0000, PREDICTED, NO_WANT},
        '{MODE_DELETE, 32'h0000_3039, PREDICTED, NO_WANT},
        '{MODE_DELETE, 32'h7fff_ffff, PREDICTED, NO_WANT}
    };

    // applies one operation to the ascending list and returns the response it yields
    function automatic sli_result_t apply_list_op(input logic m, input logic [VAL_W-1:0] v);
        int          operand;
        int          pos;
        sli_result_t r;
        operand = signed'(v);
        pos     = 0;
        r       = '0;
        if (m == MODE_INSERT)
        begin
            if (sorted_vals.size() >= CAPACITY)
                r.status = STATUS_FULL;
            else
            begin
                while (pos < sorted_vals.size() && sorted_vals[pos] < operand)
                    pos++;
                sorted_vals.insert(pos, operand);
                r.status = STATUS_OK;
            end
        end
        else if (sorted_vals.size() == 0)
            r.status = STATUS_EMPTY;
        else
        begin
            while (pos < sorted_vals.size() && sorted_vals[pos] != operand)
                pos++;
            if (pos >= sorted_vals.size())
                r.status = STATUS_NOT_FOUND;
            else
            begin
                sorted_vals.delete(pos);
                r.status = STATUS_OK;
            end
        end
        r.count = COUNT_W'(sorted_vals.size());
        if (sorted_vals.size() > 0)
        begin
            r.smallest       = sorted_vals[0];
            r.smallest_valid = 1'b1;
        end
        return r;
    endfunction

    task automatic note_mismatch(input string what, input logic [VAL_W-1:0] want_v,
                                 input logic [VAL_W-1:0] got_v);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
            $display("mismatch at %0t: %s expected %0h got %0h", $realtime, what, want_v, got_v);
    endtask

    // mostly fill-then-drain sequences; deletes usually name a stored value
    task automatic pick_random_op(output logic m, output logic [VAL_W-1:0] v);
        int fill;
        fill = sorted_vals.size();
        if (fill >= CAPACITY)
            filling = 1'b0;
        else if (fill == 0)
            filling = 1'b1;
        m = ($urandom_range(0, 99) < (filling ? 70 : 30)) ? MODE_INSERT : MODE_DELETE;
        if (m == MODE_DELETE && fill > 0 && $urandom_range(0, 99) < 80)
            v = sorted_vals[$urandom_range(0, fill - 1)];
        else
        begin
            case ($urandom_range(0, 19))
                0, 1, 2, 3, 4, 5, 6, 7: v = VAL_W'($urandom_range(0, 16)) - VAL_W'(8);
                8, 9, 10:
                begin
                    case ($urandom_range(0, 3))
                        0:       v = 32'h8000_0000;
                        1:       v = 32'h7fff_ffff;
                        2:       v = 32'h0000_0000;
                        default: v = 32'hffff_ffff;
                    endcase
                end
                default: v = $urandom;
            endcase
        end
    endtask

    task automatic send_item(input logic m, input logic [VAL_W-1:0] v, input row_note_t note);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            req_ch.valid <= 1'b0;
            @(negedge clk);
        end
        row_notes.push_back(note);
        if (m == MODE_INSERT)
            inserts_sent++;
        else
            deletes_sent++;
        req_ch.valid <= 1'b1;
        req_ch.mode  <= m;
        req_ch.value <= v;
        do
            @(posedge clk);
        while (!(req_ch.valid && req_ch.ready));
        @(negedge clk);
    endtask

    // predicts at each request transfer, checks at each response transfer
    always @(posedge clk)
    begin
        sli_result_t want;
        sli_result_t got;
        row_note_t   note;
        bit          moved;
        moved = 1'b0;
        if (rst_n)
        begin
            if (req_ch.valid && req_ch.ready)
            begin
                moved = 1'b1;
                want  = apply_list_op(req_ch.mode, req_ch.value);
                note  = row_notes.pop_front();
                pending_results.push_back(note.typed ? note.want : want);
                if (sorted_vals.size() > peak_fill)
                    peak_fill = sorted_vals.size();
            end
            if (rsp_ch.valid && rsp_ch.ready)
            begin
                moved = 1'b1;
                got   = '{rsp_ch.status, rsp_ch.count, rsp_ch.smallest, rsp_ch.smallest_valid};
                if (pending_results.size() == 0)
                    note_mismatch("response with nothing pending, smallest", '0, got.smallest);
                else
                begin
                    want = pending_results.pop_front();
                    results_checked++;
                    status_seen[want.status]++;
                    if (got.status !== want.status)
                        note_mismatch("status", VAL_W'(want.status), VAL_W'(got.status));
                    if (got.count !== want.count)
                        note_mismatch("count", VAL_W'(want.count), VAL_W'(got.count));
                    if (got.smallest !== want.smallest)
                        note_mismatch("smallest", want.smallest, got.smallest);
                    if (got.smallest_valid !== want.smallest_valid)
                        note_mismatch("smallest_valid", VAL_W'(want.smallest_valid),
                                      VAL_W'(got.smallest_valid));
                end
            end
            quiet_cycles <= moved ? 0 : quiet_cycles + 1;
        end
    end

    initial
    begin
        wait (rst_n);
        while (quiet_cycles < QUIET_LIMIT)
            @(posedge clk);
        $display("watchdog: no transfer for %0d cycles, %0d responses pending",
                 QUIET_LIMIT, pending_results.size());
        $display("** sorted_list_insert_delete: FAILED **");
        $finish;
    end

    // response side: random back-pressure plus one long hold-off on request
    initial
    begin
        rsp_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (holds_done < hold_requests)
            begin
                holds_done++;
                rsp_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES - 1)
                    @(negedge clk);
            end
            else
                rsp_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    initial
    begin
        logic             pick_mode;
        logic [VAL_W-1:0] pick_value;
        req_ch.valid = 1'b0;
        req_ch.mode  = MODE_INSERT;
        req_ch.value = '0;
        repeat (5)
            @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (directed_rows[i])
            send_item(directed_rows[i].mode, directed_rows[i].value,
                      row_note_t'{directed_rows[i].typed, directed_rows[i].want});

        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (n == RANDOM_ITEMS / 3)
            begin
                send_idle_pct = 65;
                recv_idle_pct = 29;
            end
            if (n == 2 * RANDOM_ITEMS / 3)
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
                hold_requests++;
            end
            pick_random_op(pick_mode, pick_value);
            send_item(pick_mode, pick_value, row_note_t'{PREDICTED, NO_WANT});
        end
        req_ch.valid <= 1'b0;

        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES)
            @(posedge clk);

        $display("checked %0d responses from %0d inserts and %0d deletes",
                 results_checked, inserts_sent, deletes_sent);
        $display("list filled to %0d of %0d; status mix: ok %0d, full %0d, not found %0d, empty %0d",
                 peak_fill, CAPACITY, status_seen[STATUS_OK], status_seen[STATUS_FULL],
                 status_seen[STATUS_NOT_FOUND], status_seen[STATUS_EMPTY]);
        $display("%0d mismatches", mismatch_count);
        if (mismatch_count == 0)
            $display("** sorted_list_insert_delete: PASSED **");
        else
            $display("** sorted_list_insert_delete: FAILED **");
        $finish;
    end

endmodule
